// File: src/sorted_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority queue - assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq checker: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq checker: next-cycle property violated");

`endif

// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue - package
// Shared payload types, operation and status codes, control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  typedef logic signed [31:0] value_t;
  typedef logic signed [15:0] prio_t;
  typedef logic        [1:0]  mode_t;
  typedef logic        [1:0]  status_t;

  // operation codes
  localparam mode_t MODE_ENQUEUE  = 2'd0;
  localparam mode_t MODE_DEQUEUE  = 2'd1;
  localparam mode_t MODE_CONTAINS = 2'd2;
  localparam mode_t MODE_NOP      = 2'd3;

  // status codes
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_UNDERFLOW = 2'd1;
  localparam status_t STATUS_OVERFLOW  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming transaction
    logic exec;   // apply the operation to the slot chain
    logic resp;   // result is on the ports this cycle
  } cmd_t;

endpackage

`default_nettype wire

// File: src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue - controller
// One-hot sequencer: idle, execute, respond.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output spq_pkg::cmd_t cmd_o
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StResp = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) state_d = StExec;
      end
      StExec: state_d = StResp;
      StResp: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o     = (state_q != StIdle);
  assign cmd_o.load = (state_q == StIdle) && start_i;
  assign cmd_o.exec = (state_q == StExec);
  assign cmd_o.resp = (state_q == StResp);

endmodule

`default_nettype wire

// File: src/spq_datapath.sv
// ----------------------------------------------------------------------------
// Sorted priority queue - datapath
// Shifting sorted slot chain with per-slot compare and match.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath #(
  parameter  int unsigned CAPACITY = 16,
  localparam int unsigned CntW     = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spq_pkg::cmd_t    cmd_i,
  input  spq_pkg::mode_t   mode_i,
  input  spq_pkg::value_t  item_value_i,
  input  spq_pkg::prio_t   item_priority_i,
  output spq_pkg::status_t status_o,
  output spq_pkg::value_t  removed_value_o,
  output logic             found_o,
  output logic             head_valid_o,
  output spq_pkg::value_t  head_value_o,
  output logic [CntW-1:0]  occupancy_o
);
  import spq_pkg::*;

  // captured transaction
  mode_t  mode_q;
  value_t ival_q;
  prio_t  ipri_q;

  // slot chain, slot 0 is the head
  value_t val_q [CAPACITY];
  prio_t  pri_q [CAPACITY];
  value_t val_d [CAPACITY];
  prio_t  pri_d [CAPACITY];
  logic [CntW-1:0] count_q, count_d;

  logic [CAPACITY-1:0] vld, ge, match_d, match_q;
  status_t status_q, status_d;
  value_t  removed_q, removed_d;

  logic full, empty, do_enq, do_deq;

  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign do_enq = (mode_q == MODE_ENQUEUE) && !full;
  assign do_deq = (mode_q == MODE_DEQUEUE) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign vld[i]     = (CntW'(i) < count_q);
    // slots past the fill level count as lower priority than anything
    assign ge[i]      = !vld[i] || (pri_q[i] >= ipri_q);
    assign match_d[i] = (mode_q == MODE_CONTAINS) && vld[i] && (val_q[i] == ival_q);

    always_comb begin
      val_d[i] = val_q[i];
      pri_d[i] = pri_q[i];
      if (do_enq) begin
        if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
          val_d[i] = val_q[(i > 0) ? i - 1 : 0];
          pri_d[i] = pri_q[(i > 0) ? i - 1 : 0];
        end else if (ge[i]) begin
          val_d[i] = ival_q;
          pri_d[i] = ipri_q;
        end
      end else if (do_deq && i < CAPACITY - 1) begin
        val_d[i] = val_q[(i < CAPACITY - 1) ? i + 1 : i];
        pri_d[i] = pri_q[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    status_d  = STATUS_OK;
    removed_d = '0;
    case (mode_q)
      MODE_ENQUEUE: begin
        if (full) status_d = STATUS_OVERFLOW;
        else      count_d  = count_q + CntW'(1);
      end
      MODE_DEQUEUE: begin
        if (empty) begin
          status_d = STATUS_UNDERFLOW;
        end else begin
          removed_d = val_q[0];
          count_d   = count_q - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      ival_q <= item_value_i;
      ipri_q <= item_priority_i;
    end
    if (cmd_i.exec) begin
      val_q     <= val_d;
      pri_q     <= pri_d;
      match_q   <= match_d;
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign found_o         = |match_q;
  assign head_valid_o    = !empty;
  assign head_value_o    = empty ? '0 : val_q[0];
  assign occupancy_o     = count_q;

endmodule

`default_nettype wire

// File: src/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue - top level
// Bounded queue kept in priority order; enqueue, dequeue and contains.
// ----------------------------------------------------------------------------
// Sequence: a transaction taken in idle is applied to the slot chain in the
//   execute state; its result is strobed (valid_o) in the respond state.
// Handshake: a new transaction is taken only in idle, after the respond
//   state of the last; busy is high in the execute and respond states.
// Reset: rst_ni clears the sequencer and fill count; slots stay unseen until
//   written. The receiver cannot stall; valid_o is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core #(
  parameter  int unsigned CAPACITY = 16,
  localparam int unsigned CntW     = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command side
  input  logic             start,
  output logic             busy,
  input  spq_pkg::mode_t   mode_i,
  input  spq_pkg::value_t  item_value_i,
  input  spq_pkg::prio_t   item_priority_i,
  // result side
  output logic             valid_o,
  output spq_pkg::status_t status_o,
  output spq_pkg::value_t  removed_value_o,
  output logic             found_o,
  output logic             head_valid_o,
  output spq_pkg::value_t  head_value_o,
  output logic [CntW-1:0]  occupancy_o
);
  import spq_pkg::*;

  cmd_t cmd;

  // Sequencer: a transaction is captured in idle, applied to the slot
  // chain in the execute cycle, and its result is presented for one cycle.
  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // Slot chain: every slot compares its priority with the new entry in
  // parallel, so an insert or a removal is a single shift of the chain.
  // Ties place the new entry ahead, so newer entries go first.
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mode_i          (mode_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .found_o         (found_o),
    .head_valid_o    (head_valid_o),
    .head_value_o    (head_value_o),
    .occupancy_o     (occupancy_o)
  );

  // Result fields are held in registers; the strobe marks the one cycle
  // in which they belong to the finished transaction.
  assign valid_o = cmd.resp;

endmodule

`default_nettype wire

// File: src/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue - port checker
// Concurrent checks on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_core_defines.svh"

module spq_checker #(
  parameter  int unsigned CAPACITY = 16,
  localparam int unsigned CntW     = $clog2(CAPACITY + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             valid_o,
  input spq_pkg::status_t status_o,
  input logic             head_valid_o,
  input logic [CntW-1:0]  occupancy_o
);
  import spq_pkg::*;

  `SPQ_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `SPQ_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, valid_o, !valid_o)
  `SPQ_ASSERT_NOW(a_head_vs_occ, clk_i, rst_ni, valid_o, head_valid_o == (occupancy_o != '0))
  `SPQ_ASSERT_NOW(a_overflow_full, clk_i, rst_ni, valid_o && status_o == STATUS_OVERFLOW, occupancy_o == CntW'(CAPACITY))

endmodule

bind sorted_priority_queue_core spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .status_o     (status_o),
  .head_valid_o (head_valid_o),
  .occupancy_o  (occupancy_o)
);

`default_nettype wire

// File: test/tb_sorted_priority_queue_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue - testbench
// Drives enqueue, dequeue, contains and unused-mode commands through the
// start/busy handshake in random bursts. A mirror of the slot chain is kept
// alongside, and every strobed result is checked field by field.
// ----------------------------------------------------------------------------

module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int          N_RANDOM  = 1500;     // random operations, unused mode excluded
  localparam int          LIMIT     = 200000;   // cycles before the run is declared hung
  localparam int          MAX_PRINT = 40;       // mismatch lines shown before going quiet

  // one command as presented on the ports
  typedef struct packed {
    mode_t  mode;
    value_t value;
    prio_t  prio;
  } op_t;

  // one result as strobed on valid_o
  typedef struct packed {
    status_t          status;
    value_t           removed;
    logic             found;
    logic             head_valid;
    value_t           head;
    logic [CNT_W-1:0] occupancy;
  } outcome_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             start           = 1'b0;
  logic             busy;
  mode_t            mode_i          = MODE_ENQUEUE;
  value_t           item_value_i    = '0;
  prio_t            item_priority_i = '0;
  logic             valid_o;
  status_t          status_o;
  value_t           removed_value_o;
  logic             found_o;
  logic             head_valid_o;
  value_t           head_value_o;
  logic [CNT_W-1:0] occupancy_o;

  sorted_priority_queue_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .found_o        (found_o),
    .head_valid_o   (head_valid_o),
    .head_value_o   (head_value_o),
    .occupancy_o    (occupancy_o)
  );

  // --------------------------------------------------------------------------
  // Clock and reset: reset is held from time zero and released on a falling
  // edge so it never races the sampling edge.
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Mirror of the slot chain. Slot 0 is the head; only slots below
  // mirror_count are meaningful.
  // --------------------------------------------------------------------------
  value_t mirror_value [CAPACITY];
  prio_t  mirror_prio  [CAPACITY];
  int     mirror_count = 0;

  op_t      op_queue[$];        // commands not yet driven
  outcome_t awaited_results[$]; // predicted results, oldest first

  int issued_cnt   = 0;         // commands put on the ports (driver side)
  int accepted_cnt = 0;         // transactions taken by the block
  int err_cnt      = 0;
  int n_results    = 0;
  int n_overflow   = 0;
  int n_underflow  = 0;
  int n_hits       = 0;
  int n_full       = 0;
  int n_ties       = 0;

  // Apply one command to the mirror and return the result it should yield.
  function automatic outcome_t queue_step(input op_t op);
    outcome_t r;
    int       pos;
    int       i;
    r = '0;
    case (op.mode)
      MODE_ENQUEUE: begin
        if (mirror_count >= CAPACITY) begin
          r.status = STATUS_OVERFLOW;
        end else begin
          // newest entry goes ahead of every equal or larger priority
          pos = 0;
          while (pos < mirror_count && $signed(mirror_prio[pos]) < $signed(op.prio))
            pos++;
          if (mirror_count != 0 && pos == 0 && mirror_prio[0] == op.prio)
            n_ties++;
          for (i = mirror_count; i > pos; i--) begin
            mirror_value[i] = mirror_value[i-1];
            mirror_prio[i]  = mirror_prio[i-1];
          end
          mirror_value[pos] = op.value;
          mirror_prio[pos]  = op.prio;
          mirror_count++;
        end
      end
      MODE_DEQUEUE: begin
        if (mirror_count == 0) begin
          r.status = STATUS_UNDERFLOW;
        end else begin
          r.removed = mirror_value[0];
          for (i = 1; i < mirror_count; i++) begin
            mirror_value[i-1] = mirror_value[i];
            mirror_prio[i-1]  = mirror_prio[i];
          end
          mirror_count--;
        end
      end
      MODE_CONTAINS: begin
        for (i = 0; i < mirror_count; i++)
          if (mirror_value[i] == op.value) r.found = 1'b1;
      end
      default: ;  // unused mode: no change, peek still reported
    endcase
    r.head_valid = (mirror_count != 0);
    r.head       = (mirror_count != 0) ? mirror_value[0] : '0;
    r.occupancy  = CNT_W'(mirror_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: expected %h, got %h",
                                n_results, name, want, got));
  endtask

  // --------------------------------------------------------------------------
  // Driver. Inputs move on the falling edge. A command stays on the ports
  // until the monitor has counted its transaction; then the driver either
  // idles for the current gap or puts up the next command. Bursts and gaps
  // are of random length, with some gap-free stretches.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    op_t nxt;
    if (rst_ni) begin
      if (start && accepted_cnt != issued_cnt) begin
        // still waiting for the block to take it
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left  = gap_left - 1;
      end else if (op_queue.size() > 0) begin
        nxt              = op_queue.pop_front();
        mode_i          <= nxt.mode;
        item_value_i    <= nxt.value;
        item_priority_i <= nxt.prio;
        start           <= 1'b1;
        issued_cnt       = issued_cnt + 1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled on the rising edge, i.e. the values that
  // held through the cycle just ending. A strobed result is checked before
  // the transaction taken at the same edge is predicted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    outcome_t want;
    op_t      taken;
    if (rst_ni) begin
      if (valid_o) begin
        n_results++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %h head %h",
                                    status_o, head_value_o));
        end else begin
          want = awaited_results.pop_front();
          check_field("status",        32'(want.status),     32'(status_o));
          check_field("removed_value", want.removed,         removed_value_o);
          check_field("found",         32'(want.found),      32'(found_o));
          check_field("head_valid",    32'(want.head_valid), 32'(head_valid_o));
          check_field("head_value",    want.head,            head_value_o);
          check_field("occupancy",     32'(want.occupancy),  32'(occupancy_o));
          if (want.status == STATUS_OVERFLOW)  n_overflow++;
          if (want.status == STATUS_UNDERFLOW) n_underflow++;
          if (want.found)                      n_hits++;
          if (want.occupancy == CAPACITY)      n_full++;
        end
      end
      if (start && !busy) begin
        taken = '{mode: mode_i, value: item_value_i, prio: item_priority_i};
        awaited_results.push_back(queue_step(taken));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Hang guard: the slowest legal run is well under a tenth of this.
  // --------------------------------------------------------------------------
  int cycle_cnt = 0;

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, awaited_results.size());
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test.
  // --------------------------------------------------------------------------
  function automatic prio_t pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return prio_t'($urandom_range(0, 6)) - prio_t'(3);  // dense, many ties
    if (r < 65) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    return prio_t'($urandom);
  endfunction

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'sh7fffffff;
    if (r == 1) return 32'sh80000000;
    if (r == 2) return '0;
    if (r == 3) return '1;
    return value_t'($urandom);
  endfunction

  initial begin
    value_t seen[$];   // recently enqueued values, so contains can hit
    int     done;
    int     seg_len;
    int     seg_kind;
    int     enq_pct;
    int     deq_pct;
    int     r;
    op_t    op;

    // directed: empty-queue corner cases first
    op_queue.push_back('{MODE_DEQUEUE,  32'sh0,        16'sh0});
    op_queue.push_back('{MODE_CONTAINS, 32'sh0,        16'sh0});
    op_queue.push_back('{MODE_NOP,      32'shffffffff, 16'shffff});
    // extremes, then a new entry tying the head's priority
    op_queue.push_back('{MODE_ENQUEUE,  32'sh7fffffff, 16'sh7fff});
    op_queue.push_back('{MODE_ENQUEUE,  32'sh80000000, 16'sh8000});
    op_queue.push_back('{MODE_ENQUEUE,  32'shffffffff, 16'sh8000});
    op_queue.push_back('{MODE_ENQUEUE,  32'sh0,        16'sh0});
    op_queue.push_back('{MODE_ENQUEUE,  32'sh5555aaaa, 16'sh7fff});
    // fill to capacity, then one more to overflow
    for (int k = 0; k < CAPACITY - 5; k++)
      op_queue.push_back('{MODE_ENQUEUE, value_t'(32'h100 + k), prio_t'(k % 4 - 1)});
    op_queue.push_back('{MODE_ENQUEUE,  32'sh12345678, 16'sh8000});
    op_queue.push_back('{MODE_CONTAINS, 32'sh80000000, 16'sh0});
    op_queue.push_back('{MODE_CONTAINS, 32'sh12345678, 16'sh0});
    op_queue.push_back('{MODE_NOP,      32'sh0,        16'sh0});
    op_queue.push_back('{MODE_DEQUEUE,  32'sh0,        16'sh0});

    // random: segments that lean towards filling, draining, an even mix or
    // lookups, so the queue swings between empty and full many times
    done = 0;
    while (done < N_RANDOM) begin
      seg_len  = $urandom_range(8, 40);
      seg_kind = $urandom_range(0, 3);
      case (seg_kind)
        0:       begin enq_pct = 75; deq_pct = 15; end
        1:       begin enq_pct = 15; deq_pct = 75; end
        2:       begin enq_pct = 40; deq_pct = 40; end
        default: begin enq_pct = 25; deq_pct = 25; end
      endcase
      for (int k = 0; k < seg_len; k++) begin
        r        = $urandom_range(0, 99);
        op.value = pick_value();
        op.prio  = pick_prio();
        if (r == 99)                     op.mode = MODE_NOP;
        else if (r < enq_pct)            op.mode = MODE_ENQUEUE;
        else if (r < enq_pct + deq_pct)  op.mode = MODE_DEQUEUE;
        else                             op.mode = MODE_CONTAINS;
        if (op.mode == MODE_ENQUEUE) begin
          seen.push_back(op.value);
          if (seen.size() > 64) void'(seen.pop_front());
        end
        if (op.mode == MODE_CONTAINS && seen.size() > 0 && $urandom_range(0, 9) < 6)
          op.value = seen[$urandom_range(0, seen.size() - 1)];
        op_queue.push_back(op);
        if (op.mode != MODE_NOP) done++;
      end
    end

    // everything driven and taken, then every result back, then a short
    // settle so a stray late strobe is still caught
    while (op_queue.size() != 0 || start || accepted_cnt != issued_cnt)
      @(posedge clk_i);
    while (awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

    $display("%0d transactions checked in %0d cycles: %0d overflows, %0d underflows,",
             n_results, cycle_cnt, n_overflow, n_underflow);
    $display("%0d contains hits, %0d results at full capacity, %0d head ties, %0d mismatches",
             n_hits, n_full, n_ties, err_cnt);
    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
